### rtl/qn_pkg.sv
// Shared constants, types and register codes for the quaternion normalizer.
`default_nettype none
package qn_pkg;

	localparam int FRAC_BITS = 14;
	localparam int COMP_W    = 16;
	localparam int NORM_W    = 17;
	localparam int SQ_W      = 2 * COMP_W - 1;
	localparam int SUM_W     = 2 * COMP_W + 1;
	localparam int RAD_W     = 2 * NORM_W;
	localparam int QUOT_W    = FRAC_BITS + 1;
	localparam int NUM_COMP  = 4;

	localparam logic [NORM_W-1:0] LOW_LIMIT_RESET  = NORM_W'(16220);
	localparam logic [NORM_W-1:0] HIGH_LIMIT_RESET = NORM_W'(16548);

	// Register index, taken from paddr[2]
	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		comp_t [NUM_COMP-1:0] comp;
		logic [NORM_W-1:0]    norm;
		logic                 last;
	} front_item_t;

	typedef struct packed {
		logic [NORM_W-1:0] low;
		logic [NORM_W-1:0] high;
	} limits_t;

endpackage
`default_nettype wire

### rtl/qn_front.sv
// Front end: accepts a quaternion, sums the squares and takes the floor square root.
`default_nettype none
module qn_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [63:0]         s_tdata,   // qx, qy, qz, qw
	input  logic                s_tlast,   // last_in_batch
	output qn_pkg::front_item_t item,
	output logic                push,
	input  logic                full
);
	import qn_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_SQ   = 4'b0010,
		F_ROOT = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	localparam int CNT_W = $clog2(NORM_W);

	fstate_t                    state_q;
	logic [CNT_W-1:0]           cnt_q;
	comp_t [NUM_COMP-1:0]       comp_q;
	logic                       last_q;
	logic [SQ_W-1:0]            prod_q;
	logic [SUM_W-1:0]           sum_q;
	logic [RAD_W-1:0]           rad_q;
	logic [NORM_W:0]            rem_q;
	logic [NORM_W-1:0]          root_q;

	logic                       accept;
	logic signed [2*COMP_W-1:0] square;
	logic [SUM_W-1:0]           sum_next;
	logic [NORM_W+2:0]          trial;
	logic [NORM_W+2:0]          tcmp;
	logic                       ge;

	assign s_tready = (state_q == F_IDLE) || ((state_q == F_PUSH) && !full);
	assign accept   = s_tvalid && s_tready;
	assign push     = (state_q == F_PUSH) && !full;

	assign item = {comp_q, root_q, last_q};

	assign square   = comp_q[cnt_q[1:0]] * comp_q[cnt_q[1:0]];
	assign sum_next = sum_q + SUM_W'(prod_q);

	// one root bit per cycle: bring down two radicand bits, try 4r+1
	assign trial = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign tcmp  = {1'b0, root_q, 2'b01};
	assign ge    = trial >= tcmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE, F_PUSH: begin
					if (accept) begin
						state_q <= F_SQ;
						cnt_q   <= '0;
					end else if (push) begin
						state_q <= F_IDLE;
					end
				end
				F_SQ: begin
					if (cnt_q == CNT_W'(NUM_COMP)) begin
						state_q <= F_ROOT;
						cnt_q   <= CNT_W'(NORM_W - 1);
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				F_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				comp_q[i] <= s_tdata[COMP_W*i +: COMP_W];
			end
			last_q <= s_tlast;
			sum_q  <= '0;
		end else if (state_q == F_SQ) begin
			if (cnt_q != CNT_W'(NUM_COMP)) begin
				prod_q <= square[SQ_W-1:0];
			end
			if (cnt_q != '0) begin
				sum_q <= sum_next;
			end
			if (cnt_q == CNT_W'(NUM_COMP)) begin
				rad_q  <= RAD_W'(sum_next);
				rem_q  <= '0;
				root_q <= '0;
			end
		end else if (state_q == F_ROOT) begin
			rem_q  <= ge ? (NORM_W+1)'(trial - tcmp) : (NORM_W+1)'(trial);
			root_q <= {root_q[NORM_W-2:0], ge};
			rad_q  <= rad_q << 2;
		end
	end

endmodule
`default_nettype wire

### rtl/qn_fifo.sv
// Two-entry queue between the front end and the divider back end.
`default_nettype none
module qn_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qn_pkg::front_item_t wr_item,
	output logic                full,
	input  logic                pop,
	output qn_pkg::front_item_t rd_item,
	output logic                empty
);
	import qn_pkg::*;

	front_item_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

### rtl/qn_back.sv
// Back end: four divider lanes, limit check, batch flag and output register.
`default_nettype none
module qn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qn_pkg::front_item_t item,
	input  logic                empty,
	output logic                pop,
	input  qn_pkg::limits_t     limits,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [87:0]         m_tdata,   // nx, ny, nz, nw, norm_value, zero pad
	output logic [1:0]          m_tuser,   // norm_ok, batch_ok
	output logic                m_tlast    // last_out
);
	import qn_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} bstate_t;

	localparam int CNT_W = $clog2(QUOT_W);

	bstate_t                      state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         run_ok_q;
	logic [NORM_W-1:0]            norm_q;
	logic                         ok_q;
	logic                         bok_q;
	logic                         last_q;
	logic [NUM_COMP-1:0]          neg_q;
	logic [NUM_COMP-1:0]          lsb_q;
	logic [NORM_W-1:0]            rem_q  [NUM_COMP];
	logic [QUOT_W-1:0]            quot_q [NUM_COMP];

	logic                         ok;
	logic                         bok;
	logic                         fire;
	logic [COMP_W-1:0]            mag    [NUM_COMP];
	logic [NORM_W:0]              part   [NUM_COMP];
	logic [NUM_COMP-1:0]          ge;
	logic [NUM_COMP-1:0][COMP_W-1:0] res;

	function automatic logic [COMP_W-1:0] finish(logic neg, logic [QUOT_W-1:0] q);
		logic [31:0] qe;
		qe = 32'(q);
		if (neg) begin
			if (qe > 32'd32768) qe = 32'd32768;
			return COMP_W'(32'd0 - qe);
		end
		if (qe > 32'd32767) qe = 32'd32767;
		return qe[COMP_W-1:0];
	endfunction

	assign pop  = (state_q == B_IDLE) && !empty;
	assign fire = (state_q == B_DONE) && (!m_tvalid || m_tready);

	assign ok  = (item.norm != '0) && (item.norm > limits.low) && (item.norm < limits.high);
	assign bok = run_ok_q && ok;

	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			mag[i]  = item.comp[i][COMP_W-1] ? COMP_W'(-item.comp[i]) : item.comp[i];
			// only the first step brings down a dividend bit; the rest are zero
			part[i] = {rem_q[i], (cnt_q == CNT_W'(FRAC_BITS)) ? lsb_q[i] : 1'b0};
			ge[i]   = part[i] >= {1'b0, norm_q};
			res[i]  = (norm_q == '0) ? '0 : finish(neg_q[i], quot_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			run_ok_q <= 1'b1;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q  <= B_DIV;
						cnt_q    <= CNT_W'(FRAC_BITS);
						run_ok_q <= item.last ? 1'b1 : bok;
					end
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				B_DONE: begin
					if (fire) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (fire) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			norm_q <= item.norm;
			ok_q   <= ok;
			bok_q  <= bok;
			last_q <= item.last;
			for (int i = 0; i < NUM_COMP; i++) begin
				neg_q[i]  <= item.comp[i][COMP_W-1];
				lsb_q[i]  <= mag[i][0];
				rem_q[i]  <= NORM_W'(mag[i] >> 1);
				quot_q[i] <= '0;
			end
		end else if (state_q == B_DIV) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				rem_q[i]  <= ge[i] ? NORM_W'(part[i] - {1'b0, norm_q}) : part[i][NORM_W-1:0];
				quot_q[i] <= {quot_q[i][QUOT_W-2:0], ge[i]};
			end
		end
		if (fire) begin
			m_tdata <= {7'b0, norm_q, res[3], res[2], res[1], res[0]};
			m_tuser <= {bok_q, ok_q};
			m_tlast <= last_q;
		end
	end

endmodule
`default_nettype wire

### rtl/quaternion_normalizer_top.sv
// Quaternion normalizer: stream ports, limit registers, front end, queue and back end.
// Input beat: s_tdata carries qx, qy, qz, qw (signed Q1.14), s_tlast marks the last
// quaternion of a batch. Output beat: m_tdata carries nx, ny, nz, nw and norm_value,
// m_tuser carries norm_ok and batch_ok, m_tlast copies the input's last mark.
// The front end works on one beat at a time, with one shared squarer and a bit-serial
// square root, and takes no new beat before it has handed the last one to the queue.
// The back end divides all four components in parallel and overlaps with the front
// end through a two-entry queue.
// The APB port holds norm_low_limit at address 0 and norm_high_limit at address 4;
// write them only while no beat is in flight.
// Reset clears the queue, the running batch flag (to one) and loads the default limits.
// When the receiver stalls, the output register holds its beat, the back end finishes
// one more item and waits, the queue fills, and then s_tready drops.
`default_nettype none
module quaternion_normalizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // qx, qy, qz, qw
	input  logic        s_tlast,   // last_in_batch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // nx, ny, nz, nw, norm_value, zero pad
	output logic [1:0]  m_tuser,   // norm_ok, batch_ok
	output logic        m_tlast,   // last_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qn_pkg::*;

	limits_t     limits_q;
	front_item_t push_item;
	front_item_t pop_item;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.low  <= LOW_LIMIT_RESET;
			limits_q.high <= HIGH_LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LOW:  limits_q.low  <= pwdata[NORM_W-1:0];
				REG_HIGH: limits_q.high <= pwdata[NORM_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LOW:  prdata = 32'(limits_q.low);
			REG_HIGH: prdata = 32'(limits_q.high);
			default:  prdata = '0;
		endcase
	end

	qn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.item     (push_item),
		.push     (push),
		.full     (full)
	);

	qn_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.rd_item (pop_item),
		.empty   (empty)
	);

	qn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (pop_item),
		.empty    (empty),
		.pop      (pop),
		.limits   (limits_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### tb/quaternion_normalizer_checker.sv
// Scoreboard for the quaternion normalizer: predicts every output beat and compares it.
module quaternion_normalizer_checker
	import qn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // qx, qy, qz, qw
	input  logic        s_tlast,   // last_in_batch
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // nx, ny, nz, nw, norm_value, zero pad
	input  logic [1:0]  m_tuser,   // norm_ok, batch_ok
	input  logic        m_tlast,   // last_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding,
	output int          compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		comp_t             nx;
		comp_t             ny;
		comp_t             nz;
		comp_t             nw;
		logic [NORM_W-1:0] norm;
		logic              norm_ok;
		logic              batch_ok;
		logic              last;
	} unit_quat_t;

	unit_quat_t        unit_quat_q[$];
	unit_quat_t        seen;
	unit_quat_t        want;
	logic [NORM_W-1:0] low_limit;
	logic [NORM_W-1:0] high_limit;
	logic              batch_run_ok;

	// Largest r with r*r <= v, one result bit at a time from the top.
	function automatic logic [NORM_W-1:0] root_of(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int i = NORM_W - 1; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= v)
				r = trial;
		end
		return r[NORM_W-1:0];
	endfunction

	function automatic comp_t divide_comp(input comp_t c, input logic [NORM_W-1:0] nrm);
		longint mag;
		longint quo;
		if (nrm == 0)
			return '0;
		mag = (c < 0) ? -longint'(c) : longint'(c);
		quo = (mag << FRAC_BITS) / longint'(nrm);
		if (c < 0)
			return (quo > 32768) ? comp_t'(-32768) : comp_t'(-quo);
		return (quo > 32767) ? comp_t'(32767) : comp_t'(quo);
	endfunction

	// Also advances the running batch flag.
	function automatic unit_quat_t normalize(input comp_t qx, qy, qz, qw, input logic last);
		unit_quat_t        res;
		longint unsigned   sq_sum;
		logic [NORM_W-1:0] nrm;
		sq_sum = longint'(qx) * longint'(qx) + longint'(qy) * longint'(qy)
			+ longint'(qz) * longint'(qz) + longint'(qw) * longint'(qw);
		nrm = root_of(sq_sum);
		res.nx       = divide_comp(qx, nrm);
		res.ny       = divide_comp(qy, nrm);
		res.nz       = divide_comp(qz, nrm);
		res.nw       = divide_comp(qw, nrm);
		res.norm     = nrm;
		res.norm_ok  = (nrm != 0) && (nrm > low_limit) && (nrm < high_limit);
		res.batch_ok = batch_run_ok & res.norm_ok;
		res.last     = last;
		batch_run_ok = last ? 1'b1 : res.batch_ok;
		return res;
	endfunction

	initial begin
		mismatches   = 0;
		compared     = 0;
		outstanding  = 0;
		low_limit    = LOW_LIMIT_RESET;
		high_limit   = HIGH_LIMIT_RESET;
		batch_run_ok = 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_quat_q.delete();
			low_limit    = LOW_LIMIT_RESET;
			high_limit   = HIGH_LIMIT_RESET;
			batch_run_ok = 1'b1;
		end else begin
			// Retire the output beat first: it can never belong to this edge's input.
			if (m_tvalid && m_tready) begin
				seen.nx       = comp_t'(m_tdata[15:0]);
				seen.ny       = comp_t'(m_tdata[31:16]);
				seen.nz       = comp_t'(m_tdata[47:32]);
				seen.nw       = comp_t'(m_tdata[63:48]);
				seen.norm     = m_tdata[64 +: NORM_W];
				seen.norm_ok  = m_tuser[0];
				seen.batch_ok = m_tuser[1];
				seen.last     = m_tlast;
				if (unit_quat_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: output beat with nothing expected: n=(%0d %0d %0d %0d)",
							$time, seen.nx, seen.ny, seen.nz, seen.nw);
				end else begin
					want = unit_quat_q.pop_front();
					compared++;
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: beat %0d mismatch", $time, compared);
							$display("  expected n=(%0d %0d %0d %0d) norm=%0d ok=%b batch=%b last=%b",
								want.nx, want.ny, want.nz, want.nw, want.norm,
								want.norm_ok, want.batch_ok, want.last);
							$display("  actual   n=(%0d %0d %0d %0d) norm=%0d ok=%b batch=%b last=%b",
								seen.nx, seen.ny, seen.nz, seen.nw, seen.norm,
								seen.norm_ok, seen.batch_ok, seen.last);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				unit_quat_q.push_back(normalize(comp_t'(s_tdata[15:0]), comp_t'(s_tdata[31:16]),
					comp_t'(s_tdata[47:32]), comp_t'(s_tdata[63:48]), s_tlast));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_HIGH)
					high_limit = pwdata[NORM_W-1:0];
				else
					low_limit = pwdata[NORM_W-1:0];
			end
		end
		outstanding = unit_quat_q.size();
	end

endmodule

### tb/quaternion_normalizer_top_test.sv
// Stimulus and verdict for the quaternion normalizer: directed cases, random batches, limit sweeps.
module quaternion_normalizer_top_test
	import qn_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS    = 262;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // qx, qy, qz, qw
	logic        s_tlast;   // last_in_batch
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // nx, ny, nz, nw, norm_value, zero pad
	logic [1:0]  m_tuser;   // norm_ok, batch_ok
	logic        m_tlast;   // last_out
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int outstanding;
	int compared;

	int items_sent;
	int batches_done;
	int settings_used;
	int lo_cfg;
	int hi_cfg;
	int quiet_cycles;
	bit src_burst;
	bit sink_burst;

	quaternion_normalizer_top u_dut (.*);

	quaternion_normalizer_checker u_check (.*);

	always #2 clk = ~clk;

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic send_quat(input comp_t ax, ay, az, aw, input logic last);
		int gap;
		gap = draw_gap(src_burst);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {aw, az, ay, ax};
		s_tlast  = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (last)
			batches_done++;
	endtask

	// Drop valid, then hold until every expected beat is out and the pipe has emptied.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [NORM_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = {15'($urandom_range(0, 32767)), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_limits(input int low, input int high);
		wait_idle();
		apb_write({REG_LOW, 2'b00}, NORM_W'(low));
		apb_write({REG_HIGH, 2'b00}, NORM_W'(high));
		lo_cfg = low;
		hi_cfg = high;
		settings_used++;
	endtask

	task automatic make_quat(output comp_t ax, ay, az, aw);
		int  c[4];
		int  picks[7];
		real r[4];
		real mag;
		real tgt;
		int  lim;
		int  kind;
		picks = '{-32768, 32767, 0, 16384, -16384, 1, -1};
		kind = $urandom_range(0, 99);
		for (int k = 0; k < 4; k++)
			c[k] = 0;
		if (kind < 55) begin
			// Random direction scaled to a norm near 1.0 or near one of the limits.
			mag = 0.0;
			for (int k = 0; k < 4; k++) begin
				r[k] = real'(int'($urandom_range(0, 65535)) - 32768);
				mag += r[k] * r[k];
			end
			mag = $sqrt(mag);
			if (mag < 1.0) begin
				r[0] = 1.0;
				mag = 1.0;
			end
			if ($urandom_range(0, 1) == 0) begin
				tgt = 16384.0 + real'(int'($urandom_range(0, 800)) - 400);
			end else begin
				lim = ($urandom_range(0, 1) == 0) ? lo_cfg : hi_cfg;
				tgt = real'(lim + int'($urandom_range(0, 40)) - 20);
			end
			if (tgt < 1.0)
				tgt = 1.0;
			for (int k = 0; k < 4; k++)
				c[k] = $rtoi(r[k] * tgt / mag);
		end else if (kind < 70) begin
			// Single axis exactly on or next to a limit.
			lim = ($urandom_range(0, 1) == 0) ? lo_cfg : hi_cfg;
			lim = lim + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1) == 0)
				lim = -lim;
			c[$urandom_range(0, 3)] = lim;
		end else if (kind < 88) begin
			for (int k = 0; k < 4; k++)
				c[k] = int'($urandom_range(0, 65535)) - 32768;
		end else if (kind < 93) begin
			for (int k = 0; k < 4; k++)
				c[k] = int'($urandom_range(0, 8)) - 4;
		end else if (kind < 95) begin
			// zero quaternion: all components stay zero
		end else begin
			for (int k = 0; k < 4; k++)
				c[k] = picks[$urandom_range(0, 6)];
		end
		for (int k = 0; k < 4; k++) begin
			if (c[k] > 32767)
				c[k] = 32767;
			if (c[k] < -32768)
				c[k] = -32768;
		end
		ax = comp_t'(c[0]);
		ay = comp_t'(c[1]);
		az = comp_t'(c[2]);
		aw = comp_t'(c[3]);
	endtask

	task automatic random_phase(input int count);
		int    done;
		int    len;
		comp_t ax;
		comp_t ay;
		comp_t az;
		comp_t aw;
		done = 0;
		while (done < count) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
			for (int n = 1; n <= len; n++) begin
				make_quat(ax, ay, az, aw);
				send_quat(ax, ay, az, aw, n == len);
				if ($urandom_range(0, 39) == 0)
					src_burst = ~src_burst;
			end
			done += len;
		end
	endtask

	// Result side: stall a random number of cycles before taking each beat.
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			gap = draw_gap(sink_burst);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 39) == 0)
				sink_burst = ~sink_burst;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d beats outstanding",
				$time, quiet_cycles, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		items_sent    = 0;
		batches_done  = 0;
		settings_used = 1;
		quiet_cycles  = 0;
		src_burst     = 1'b0;
		sink_burst    = 1'b0;
		lo_cfg        = int'(LOW_LIMIT_RESET);
		hi_cfg        = int'(HIGH_LIMIT_RESET);
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// A batch of unit quaternions, then the zero norm as a batch of its own.
		send_quat(0, 0, 0, 16384, 1'b0);
		send_quat(16384, 0, 0, 0, 1'b0);
		send_quat(0, -16384, 0, 0, 1'b1);
		send_quat(0, 0, 0, 0, 1'b1);
		// Full-scale inputs, the most negative giving the largest norm.
		send_quat(-32768, -32768, -32768, -32768, 1'b0);
		send_quat(32767, 32767, 32767, 32767, 1'b0);
		send_quat(32767, -32768, -1, 1, 1'b0);
		send_quat(8192, 8192, 8192, 8192, 1'b1);
		// Norms on and just inside the default limits.
		send_quat(16220, 0, 0, 0, 1'b0);
		send_quat(0, 16221, 0, 0, 1'b0);
		send_quat(0, 0, -16547, 0, 1'b0);
		send_quat(0, 0, 0, -16548, 1'b1);
		send_quat(1, 0, 0, 0, 1'b1);
		send_quat(-1, -1, -1, -1, 1'b0);
		send_quat(0, 0, -16384, 0, 1'b1);
		send_quat(-8192, 8192, -8192, 8192, 1'b1);
		send_quat(12345, -23456, 0, -32768, 1'b0);
		send_quat(-32768, 0, 0, 0, 1'b1);
		random_phase(PHASE_ITEMS);

		set_limits(0, 65536);
		random_phase(PHASE_ITEMS);
		// Crossed and equal limits: nothing can pass.
		set_limits(65536, 0);
		random_phase(PHASE_ITEMS);
		set_limits(16384, 16384);
		random_phase(PHASE_ITEMS);
		lo_cfg = $urandom_range(15800, 16384);
		set_limits(lo_cfg, lo_cfg + int'($urandom_range(1, 1200)));
		random_phase(PHASE_ITEMS);
		set_limits($urandom_range(0, 65536), $urandom_range(0, 65536));
		random_phase(PHASE_ITEMS);
		set_limits(int'(LOW_LIMIT_RESET), int'(HIGH_LIMIT_RESET));
		random_phase(PHASE_ITEMS);

		wait_idle();
		$display("Covered %0d quaternions in %0d batches under %0d limit settings.",
			items_sent, batches_done, settings_used);
		$display("Compared %0d output beats, %0d mismatched, %0d never arrived.",
			compared, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
